// ----- sv/mrch_pkg.sv -----
// Shared constants for the miss-rate curve unit.
package mrch_pkg;

  localparam int MAX_BINS_DEF      = 4096;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int COUNT_W = 40;
  localparam int MISS_W  = 17;
  localparam int INDEX_W = 13;
  localparam int STAT_W  = 2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_TOTAL = 2'd2;

  localparam logic REG_TOTAL_COUNT = 1'b0;

endpackage

// ----- sv/miss_rate_curve_from_histogram_unit.sv -----
// Miss-rate curve generator: histogram bins in, Q1.FRACTION_BITS miss-rate points out.
//
//   channel | direction | beat contents
//   in_     | slave     | tdata[39:0] count; tuser[0] kind (0 bin, 1 end)
//   out_    | master    | tdata[16:0] miss_frac, [29:17] point_index, [31:30] zero;
//           |           | tuser[1:0] status; tlast is_last
//   cfg_    | APB       | 0x0 total_count (40 bits, 64-bit data)
//
// A bin beat is accepted in S_IDLE, which settles the remaining count, then runs
// FRACTION_BITS iterations of the restoring divider in S_DIV, and S_DONE hands the
// point to the output register. An end beat runs the divider twice.
// rst_n is synchronous and clears the control state and total_count.
// The output register decouples the sides: the divider keeps working while a point
// waits, and stalls only when a new point is ready and the old one is still held.
module miss_rate_curve_from_histogram_unit #(
  parameter int MAX_BINS      = mrch_pkg::MAX_BINS_DEF,
  parameter int FRACTION_BITS = mrch_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,     // [39:0] count
  input  logic [0:0]  in_tuser,     // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [16:0] miss_frac, [29:17] point_index, [31:30] zero
  output logic [1:0]  out_tuser,    // [1:0] status
  output logic        out_tlast,    // is_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW  = mrch_pkg::COUNT_W;
  localparam int MW  = mrch_pkg::MISS_W;
  localparam int XW  = mrch_pkg::INDEX_W;
  localparam int PCW = $clog2(MAX_BINS + 1);
  localparam int IW  = PCW + 1;
  localparam int QW  = FRACTION_BITS + 1;
  localparam int BW  = $clog2(FRACTION_BITS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // control state
  logic [1:0]    state_r, state_nxt;
  logic          active_r, active_nxt;
  logic [PCW-1:0] pcnt_r, pcnt_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [BW-1:0] bcnt_r, bcnt_nxt;

  // divider and point bookkeeping
  logic [CW:0]   drem_r, drem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic          cap_r, cap_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          last_r, last_nxt;
  logic          pund_r, pund_nxt;
  logic          second_r, second_nxt;
  logic [CW-1:0] after_r, after_nxt;
  logic          under2_r, under2_nxt;

  // output register
  logic [mrch_pkg::MISS_W-1:0]  out_miss_r, out_miss_nxt;
  logic [mrch_pkg::INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic                         out_last_r, out_last_nxt;
  logic [mrch_pkg::STAT_W-1:0]  out_stat_r, out_stat_nxt;

  logic          in_acc, in_kind, under, zero_tot, ge, cfg_wr, out_free;
  logic [CW-1:0] in_cnt, eff_rem, after;
  logic [PCW-1:0] eff_pcnt, pcnt_inc;
  logic [CW:0]   shl;
  logic [QW-1:0] fin;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign in_cnt     = in_tdata[CW-1:0];
  assign in_kind    = in_tuser[0];

  // First beat of a curve starts from total_count and point zero.
  assign eff_rem  = active_r ? rem_r : total_r;
  assign eff_pcnt = active_r ? pcnt_r : '0;
  assign under    = (in_cnt > eff_rem);
  assign after    = under ? '0 : (eff_rem - in_cnt);
  assign pcnt_inc = (eff_pcnt < PCW'(MAX_BINS)) ? (eff_pcnt + PCW'(1)) : eff_pcnt;
  assign zero_tot = (total_r == '0);

  // One restoring step: shift in a zero, subtract the divisor when it fits.
  assign shl = {drem_r[CW-1:0], 1'b0};
  assign ge  = (shl >= {1'b0, total_r});
  // Remaining at or above total caps at 1.0; zero total shows 0.
  assign fin = zero_tot ? '0 : (cap_r ? {1'b1, {FRACTION_BITS{1'b0}}} : quo_r);

  assign out_free = !out_valid_r || out_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    pcnt_nxt      = pcnt_r;
    rem_nxt       = rem_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    bcnt_nxt      = bcnt_r;
    drem_nxt      = drem_r;
    quo_nxt       = quo_r;
    cap_nxt       = cap_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    pund_nxt      = pund_r;
    second_nxt    = second_r;
    after_nxt     = after_r;
    under2_nxt    = under2_r;
    out_miss_nxt  = out_miss_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_stat_nxt  = out_stat_r;

    if (cfg_wr && (cfg_paddr[3] == mrch_pkg::REG_TOTAL_COUNT)) begin
      total_nxt = cfg_pwdata[CW-1:0];
    end

    // Drop the held point once taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          drem_nxt   = {1'b0, eff_rem};
          quo_nxt    = '0;
          cap_nxt    = (eff_rem >= total_r);
          bcnt_nxt   = '0;
          idx_nxt    = IW'(eff_pcnt);
          last_nxt   = 1'b0;
          pund_nxt   = in_kind ? 1'b0 : under;
          second_nxt = in_kind;
          after_nxt  = after;
          under2_nxt = under;
          // An end beat rearms the curve; a bin advances it.
          rem_nxt    = in_kind ? '0 : after;
          active_nxt = !in_kind;
          pcnt_nxt   = in_kind ? '0 : pcnt_inc;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        drem_nxt = ge ? (shl - {1'b0, total_r}) : shl;
        quo_nxt  = {quo_r[QW-2:0], ge};
        bcnt_nxt = bcnt_r + BW'(1);
        if (bcnt_r == BW'(FRACTION_BITS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_miss_nxt  = MW'(fin);
          out_idx_nxt   = XW'(idx_r);
          out_last_nxt  = last_r;
          out_stat_nxt  = zero_tot ? mrch_pkg::ST_ZERO_TOTAL :
                          (pund_r ? mrch_pkg::ST_UNDERFLOW : mrch_pkg::ST_OK);
          if (second_r) begin
            // Second point of an end beat: rate after the false infinities.
            drem_nxt   = {1'b0, after_r};
            quo_nxt    = '0;
            cap_nxt    = (after_r >= total_r);
            bcnt_nxt   = '0;
            idx_nxt    = idx_r + IW'(1);
            last_nxt   = 1'b1;
            pund_nxt   = under2_r;
            second_nxt = 1'b0;
            state_nxt  = S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      pcnt_r      <= '0;
      rem_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      bcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      pcnt_r      <= pcnt_nxt;
      rem_r       <= rem_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      bcnt_r      <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drem_r     <= drem_nxt;
    quo_r      <= quo_nxt;
    cap_r      <= cap_nxt;
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    pund_r     <= pund_nxt;
    second_r   <= second_nxt;
    after_r    <= after_nxt;
    under2_r   <= under2_nxt;
    out_miss_r <= out_miss_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_idx_r, out_miss_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[3] == mrch_pkg::REG_TOTAL_COUNT) ? 64'(total_r) : '0;

  a_acc_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_DIV)
    else $error("accepted beat did not start the divider");

  a_bcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> bcnt_r <= BW'(FRACTION_BITS - 1))
    else $error("divider step count out of range");

  a_zero_total_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r == mrch_pkg::ST_ZERO_TOTAL |-> out_miss_r == '0)
    else $error("zero-total point carries a nonzero rate");

  a_first_end_point: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && second_r && out_free |=> out_valid_r && !out_last_r)
    else $error("first point of an end beat lost or marked last");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the miss-rate curve unit: streams histograms, predicts each point.
`timescale 1ns / 100ps

module testbench;

  localparam int CW   = mrch_pkg::COUNT_W;
  localparam int MW   = mrch_pkg::MISS_W;
  localparam int XW   = mrch_pkg::INDEX_W;
  localparam int SW   = mrch_pkg::STAT_W;
  localparam int FB   = mrch_pkg::FRACTION_BITS_DEF;
  localparam int MAXB = mrch_pkg::MAX_BINS_DEF;

  // Beat kinds on in_tuser[0].
  localparam logic KIND_BIN = 1'b0;
  localparam logic KIND_END = 1'b1;

  // Register map: total_count at 8*0. The next slot is unused and must ignore writes.
  localparam logic [3:0] ADDR_TOTAL  = 4'(8 * int'(mrch_pkg::REG_TOTAL_COUNT));
  localparam logic [3:0] ADDR_UNUSED = 4'h8;

  localparam logic [CW-1:0] COUNT_MAX = '1;

  // Random stimulus size, receiver hold-off, end-of-run drain and watchdog.
  // An end beat runs the divider twice. Sender gaps and receiver stalls come from
  // pick_gap, and the single long hold-off is set by LONG_HOLD. No correct run
  // goes as long as WATCHDOG_LIMIT without any beat or register access moving.
  localparam int RANDOM_BEATS   = 400;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] count;
  } hist_beat_t;

  typedef struct packed {
    logic [MW-1:0] miss_frac;
    logic [XW-1:0] point_index;
    logic          is_last;
    logic [SW-1:0] status;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [39:0]        in_tdata = '0;    // [39:0] count
  logic [0:0]         in_tuser = '0;    // [0] kind
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;        // [16:0] miss_frac, [29:17] point_index, [31:30] zero
  logic [1:0]         out_tuser;        // [1:0] status
  logic               out_tlast;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [3:0]         cfg_paddr = '0;
  logic [63:0]        cfg_pwdata = '0;
  logic [63:0]        cfg_prdata;
  logic               cfg_pready;

  // Stimulus queue feeding the driver, and the points still owed by the block.
  hist_beat_t   pending_beats[$];
  curve_point_t expected_points[$];

  int unsigned beats_pushed = 0;
  int unsigned beats_taken = 0;
  int unsigned mismatches = 0;
  int unsigned send_wait = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  logic        gapless = 1'b0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;

  // Predictor state: own copy of the divisor and of the curve in progress.
  logic [CW-1:0] total_shadow = '0;
  logic [CW-1:0] curve_remaining = '0;
  logic          curve_running = 1'b0;
  int unsigned   curve_pos = 0;

  miss_rate_curve_from_histogram_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Build one point; a zero divisor forces rate 0 and overrides any other status.
  function automatic curve_point_t make_point(logic [CW-1:0] rem, int unsigned idx,
                                              logic last, logic [SW-1:0] st);
    curve_point_t p;
    logic [63:0]  num;
    num = 64'(rem) << FB;
    if (total_shadow == '0) begin
      p.miss_frac = '0;
      p.status    = mrch_pkg::ST_ZERO_TOTAL;
    end else begin
      // Clamp at 1.0 when the remaining count is not below the divisor.
      p.miss_frac = (rem >= total_shadow) ? MW'(64'd1 << FB)
                                          : MW'(num / 64'(total_shadow));
      p.status    = st;
    end
    p.point_index = XW'(idx);
    p.is_last     = last;
    return p;
  endfunction

  // Mostly counts that walk a curve down gradually, plus zero, full-scale and raw noise.
  function automatic logic [CW-1:0] draw_count(logic [CW-1:0] total);
    logic [63:0]  wide;
    int unsigned  r;
    wide = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return COUNT_MAX;
    if (r < 25) return wide[CW-1:0];
    return CW'(wide % (64'(total >> 2) + 64'd1));
  endfunction

  function automatic logic [CW-1:0] draw_total();
    logic [63:0]  wide;
    int unsigned  r;
    wide = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return CW'(1);
    if (r < 26) return COUNT_MAX;
    if (r < 50) return CW'($urandom_range(1, 1000));
    return wide[CW-1:0];
  endfunction

  task automatic add_beat(logic kind, logic [CW-1:0] count);
    hist_beat_t b;
    b.kind  = kind;
    b.count = count;
    pending_beats.push_back(b);
    beats_pushed++;
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic write_reg(logic [3:0] addr, logic [63:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_TOTAL) total_shadow = data[CW-1:0];
  endtask

  // Hold until every queued beat went in and every owed point came out.
  task automatic wait_idle();
    while (beats_taken != beats_pushed || expected_points.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Driver: present the next beat once the current one is taken, with random gaps.
  always @(posedge clk) begin : send_proc
    hist_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_wait <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        b = pending_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= b.count;
        in_tuser  <= b.kind;
        send_wait <= gapless ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls after taken beats, and one long hold-off on request.
  always @(posedge clk) begin : recv_proc
    int unsigned gap;
    if (!rst_n) begin
      out_tready     <= 1'b0;
      stall_left     <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      stall_left     <= LONG_HOLD;
      out_tready     <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (out_tvalid && out_tready && !gapless) begin
      gap = pick_gap();
      stall_left <= gap;
      out_tready <= (gap == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict points for each accepted input beat, check each result beat.
  always @(posedge clk) begin : check_proc
    logic          underflow;
    logic [CW-1:0] left_after;
    curve_point_t  want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        beats_taken++;
        // First beat of a curve reloads the remaining count from the divisor.
        if (!curve_running) begin
          curve_remaining = total_shadow;
          curve_pos       = 0;
          curve_running   = 1'b1;
        end
        underflow  = in_tdata > curve_remaining;
        left_after = underflow ? '0 : curve_remaining - in_tdata;
        if (in_tuser[0] == KIND_BIN) begin
          // A bin point shows the rate before its own subtraction.
          expected_points.push_back(make_point(curve_remaining, curve_pos, 1'b0,
              underflow ? mrch_pkg::ST_UNDERFLOW : mrch_pkg::ST_OK));
          curve_remaining = left_after;
          if (curve_pos < MAXB) curve_pos++;
        end else begin
          // End beat: rate before and after the false infinities, then rearm.
          expected_points.push_back(make_point(curve_remaining, curve_pos, 1'b0,
                                               mrch_pkg::ST_OK));
          expected_points.push_back(make_point(left_after, curve_pos + 1, 1'b1,
              underflow ? mrch_pkg::ST_UNDERFLOW : mrch_pkg::ST_OK));
          curve_running   = 1'b0;
          curve_pos       = 0;
          curve_remaining = '0;
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point: miss_frac %0d point_index %0d",
                 out_tdata[16:0], out_tdata[29:17]);
          mismatches++;
        end else begin
          want = expected_points.pop_front();
          if (out_tdata[16:0] !== want.miss_frac) begin
            $error("miss_frac: expected %0d, got %0d", want.miss_frac, out_tdata[16:0]);
            mismatches++;
          end
          if (out_tdata[29:17] !== want.point_index) begin
            $error("point_index: expected %0d, got %0d", want.point_index, out_tdata[29:17]);
            mismatches++;
          end
          if (out_tlast !== want.is_last) begin
            $error("is_last: expected %0d, got %0d", want.is_last, out_tlast);
            mismatches++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when no beat and no register access moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned phase_goal;
    int unsigned phase_start;
    int unsigned nbins;
    logic        first_phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A write to the unused slot must leave the divisor at zero.
    write_reg(ADDR_UNUSED, {$urandom, $urandom});
    add_beat(KIND_END, 40'd5);            // end with no bins, zero total
    add_beat(KIND_BIN, 40'd7);
    add_beat(KIND_END, COUNT_MAX);        // zero total wins over underflow
    wait_idle();

    write_reg(ADDR_TOTAL, 64'd1000);
    add_beat(KIND_BIN, 40'd0);
    add_beat(KIND_BIN, 40'd100);
    add_beat(KIND_BIN, COUNT_MAX);        // bin underflow saturates to zero
    add_beat(KIND_END, 40'd0);
    add_beat(KIND_END, 40'd1000);         // end with no bins, drains exactly
    add_beat(KIND_BIN, 40'd300);
    add_beat(KIND_BIN, 40'd200);
    add_beat(KIND_END, 40'd600);          // underflow on the second end point only
    wait_idle();

    write_reg(ADDR_TOTAL, 64'(COUNT_MAX));
    add_beat(KIND_BIN, COUNT_MAX);
    add_beat(KIND_END, 40'd0);
    wait_idle();

    // Leave a curve open, then shrink the divisor: the rate clamps at 1.0.
    write_reg(ADDR_TOTAL, 64'd1000);
    add_beat(KIND_BIN, 40'd10);
    wait_idle();
    write_reg(ADDR_TOTAL, 64'd500);
    add_beat(KIND_BIN, 40'd0);
    add_beat(KIND_END, 40'd0);
    wait_idle();

    write_reg(ADDR_TOTAL, 64'd1);
    add_beat(KIND_BIN, 40'd0);
    add_beat(KIND_BIN, 40'd1);
    add_beat(KIND_END, 40'd0);
    wait_idle();

    // Random part: phases of well-formed curves under a fresh divisor, with stray
    // end beats and curves left open across a divisor change.
    first_phase = 1'b1;
    phase_start = beats_pushed;
    while (beats_pushed < phase_start + RANDOM_BEATS) begin
      write_reg(ADDR_TOTAL, 64'(draw_total()));
      if ($urandom_range(0, 5) == 0) write_reg(ADDR_UNUSED, {$urandom, $urandom});
      gapless <= first_phase ? 1'b0 : ($urandom_range(0, 3) == 0);
      phase_goal = beats_pushed + $urandom_range(30, 70);
      while (beats_pushed < phase_goal) begin
        nbins = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        repeat (nbins) add_beat(KIND_BIN, draw_count(total_shadow));
        // Now and then end the phase with the curve still open.
        if (beats_pushed < phase_goal || $urandom_range(0, 2) != 0)
          add_beat(KIND_END, draw_count(total_shadow));
      end
      // Stall the receiver long enough for the block to back up into its input.
      if (first_phase) long_hold_req <= 1'b1;
      first_phase = 1'b0;
      wait_idle();
    end

    // Drain: let any stray point surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_points.size() != 0) begin
      $error("points never delivered: %0d", expected_points.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
